FILE: rtl/ogid_pkg.sv
// Shared types, constants and register codes for the inflated occupancy map block.
package ogid_pkg;

  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS     = 2'd2;
  localparam logic [1:0] REG_CELL_SIZE  = 2'd3;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PUT   = 2'd1;
  localparam logic [1:0] ACT_CELL  = 2'd2;
  localparam logic [1:0] ACT_BLOCK = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       coarse;
  } req_t;

  typedef struct packed {
    logic occupied;
    logic error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request and set up the row sweep
    logic step;      // process the current row, advance
    logic clr_step;  // clear one memory row, advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic skip;      // error or nothing to sweep
    logic last;      // current row is the final one of the sweep
  } sts_t;

endpackage

FILE: rtl/ogid_ctrl.sv
// Controller state machine: sequences row sweeps and the result handshake.
module ogid_ctrl
  import ogid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_INIT  = 3'd6;

  logic [2:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      // clearing pass over the map memory after reset
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_clear)  state_next = S_CLR;
        else if (sts.skip) state_next = S_WAIT;
        else               state_next = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.last) state_next = S_WAIT;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.last) state_next = S_WAIT;
      end
      // lets the final registered read or write-back settle
      S_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DEC))
    else $error("load did not start decode");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

endmodule

FILE: rtl/ogid_dp.sv
// Datapath: map memory, row sweep counters, window masks and result register.
module ogid_dp
  import ogid_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [8:0] map_width,
  input  logic [8:0] map_height,
  input  logic [4:0] inflate_radius,
  input  logic [5:0] cell_size,
  output rsp_t       rsp
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (RW > CW ? RW : CW) + 8; // room for products and sums

  // whole row held as one memory word
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  req_t          r;
  logic [XW-1:0] w, h, lo_r, hi_r, lo_c, hi_c, cur;
  logic [XW-1:0] gw, gh;
  logic          err, occ;
  logic          rd_ok;     // last-cycle row was read for a cell or block OR
  logic          wb_ok;     // last-cycle row is due for write-back
  logic [RW-1:0] wb_addr;
  logic [MAX_WIDTH-1:0] rmask, rdata;
  logic [XW-1:0] side_c, rlim, clim, rr, cc, rad;
  logic [XW-1:0] lo_r_next, hi_r_next, lo_c_next, hi_c_next;
  logic          err_next, occ_next;

  // effective map size
  always_comb begin
    w = (XW'(map_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(map_width);
    h = (XW'(map_height) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : XW'(map_height);
  end

  // block grid dimensions by repeated comparison would be long; use compare
  // of products instead: row < h/side  <=>  (row+1)*side <= h
  always_comb begin
    side_c = req.coarse ? XW'({cell_size, 1'b0}) : XW'(cell_size);
    rr     = XW'(req.row);
    cc     = XW'(req.col);
    rad    = XW'(inflate_radius);
    rlim   = (rr + 1'b1) * side_c;
    clim   = (cc + 1'b1) * side_c;
    gh     = rr * side_c;
    gw     = cc * side_c;
  end

  // sweep window and early flags for the incoming request
  always_comb begin
    err_next  = 1'b0;
    occ_next  = 1'b0;
    lo_r_next = '0;
    hi_r_next = '0;
    lo_c_next = '0;
    hi_c_next = '0;
    unique case (req.action)
      ACT_CLEAR: hi_r_next = XW'(MAX_HEIGHT);
      ACT_PUT: begin
        if (rr >= h || cc >= w) err_next = 1'b1;
        else if ((req.red | req.green | req.blue) == 8'd0) begin
          occ_next  = 1'b1;
          lo_r_next = (rr >= rad) ? rr - rad : '0;
          hi_r_next = (rr + rad < h) ? rr + rad : h;
          lo_c_next = (cc >= rad) ? cc - rad : '0;
          hi_c_next = (cc + rad < w) ? cc + rad : w;
        end
      end
      ACT_CELL: begin
        if (rr >= h || cc >= w) err_next = 1'b1;
        else begin
          lo_r_next = rr; hi_r_next = rr + 1'b1;
          lo_c_next = cc; hi_c_next = cc + 1'b1;
        end
      end
      ACT_BLOCK: begin
        if (side_c == '0 || rlim > h || clim > w) err_next = 1'b1;
        else begin
          lo_r_next = gh; hi_r_next = rlim; lo_c_next = gw; hi_c_next = clim;
        end
      end
      default: ;
    endcase
  end

  // bit mask of columns lo..hi-1
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      rmask[i] = (XW'(i) >= lo_c) && (XW'(i) < hi_c);
    end
  end

  assign sts.last = (cur + 1'b1 >= hi_r);
  assign sts.skip = err || (lo_r >= hi_r) || (lo_c >= hi_c);
  assign sts.is_clear = (r.action == ACT_CLEAR);

  // request capture, sweep counter and result flags; reset sets up the
  // clearing pass over every row
  always_ff @(posedge clk) begin
    if (rst) begin
      r    <= '0;
      err  <= 1'b0;
      occ  <= 1'b0;
      lo_r <= '0;
      hi_r <= XW'(MAX_HEIGHT);
      lo_c <= '0;
      hi_c <= '0;
      cur  <= '0;
    end else if (cmd.load) begin
      r    <= req;
      err  <= err_next;
      occ  <= occ_next;
      lo_r <= lo_r_next;
      hi_r <= hi_r_next;
      lo_c <= lo_c_next;
      hi_c <= hi_c_next;
      cur  <= lo_r_next;
    end else begin
      if (cmd.step || cmd.clr_step) cur <= cur + 1'b1;
      // OR of the row read in the previous sweep cycle
      if (rd_ok && |(rdata & rmask)) occ <= 1'b1;
    end
  end

  // pipeline registers between the registered read and its use
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
      wb_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.step && (r.action != ACT_PUT);
      wb_ok <= cmd.step && (r.action == ACT_PUT);
    end
    wb_addr <= cur[RW-1:0];
  end

  // map memory: one registered row read and one row write per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[cur[RW-1:0]] <= '0;
    end else if (wb_ok) begin
      mem[wb_addr] <= rdata | rmask;
    end
    rdata <= mem[cur[RW-1:0]];
  end

  assign rsp.occupied = occ;
  assign rsp.error    = err;

  a_clear_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_step && sts.last) |=> !err)
    else $error("clear raised an error");

endmodule

FILE: rtl/occupancy_grid_inflate_downsample.sv
// Top level: configuration registers, controller and datapath.
// A put pixel sweeps up to 2r map rows, a read block up to s or 2s rows,
// a read cell one row, and a clear sweeps every one of the MAX_HEIGHT rows
// of the map memory, one row per cycle. After reset the block clears the
// map, with the input stalled, so the map reads as zero. Requests are
// taken one at a time; the result waits in a register.
module occupancy_grid_inflate_downsample
  import ogid_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] map_width, map_height;
  logic [4:0] inflate_radius;
  logic [5:0] cell_size;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 9'd256; map_height <= 9'd256;
      inflate_radius <= 5'd3; cell_size <= 6'd10;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MAP_WIDTH:  map_width      <= pwdata[8:0];
        REG_MAP_HEIGHT: map_height     <= pwdata[8:0];
        REG_RADIUS:     inflate_radius <= pwdata[4:0];
        REG_CELL_SIZE:  cell_size      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = {23'd0, map_width};
      REG_MAP_HEIGHT: prdata = {23'd0, map_height};
      REG_RADIUS:     prdata = {27'd0, inflate_radius};
      REG_CELL_SIZE:  prdata = {26'd0, cell_size};
      default:        prdata = '0;
    endcase
  end

  ogid_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  ogid_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .map_width, .map_height,
    .inflate_radius, .cell_size, .rsp(out_data)
  );

endmodule

FILE: dv/tb_occupancy_grid_inflate_downsample.sv
// Testbench for the inflated occupancy map block: own map predictor, request driver, result checks.
module tb_occupancy_grid_inflate_downsample
  import ogid_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  occupancy_grid_inflate_downsample dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: map bits and register copies
  logic [255:0] map_bits [256];
  int unsigned  cfg_width, cfg_height, cfg_radius, cfg_cell;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   fail_count = 0;
  bit   quiet_tail = 1'b0;
  bit   hold_start = 1'b0;
  logic hold_off = 1'b0;

  function automatic void queue_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic rsp_t predict_map(req_t q);
    rsp_t rs;
    int unsigned w, h, side, r0, r1, c0, c1, rr;
    rs = '0;
    w = cfg_width > 256 ? 256 : cfg_width;
    h = cfg_height > 256 ? 256 : cfg_height;
    rr = cfg_radius;
    case (q.action)
      ACT_CLEAR: for (int k = 0; k < 256; k++) map_bits[k] = '0;
      ACT_PUT: begin
        if (q.row >= h || q.col >= w) rs.error = 1'b1;
        else if ((q.red | q.green | q.blue) == 0) begin
          rs.occupied = 1'b1;
          r0 = q.row >= rr ? q.row - rr : 0;
          r1 = q.row + rr < h ? q.row + rr : h;
          c0 = q.col >= rr ? q.col - rr : 0;
          c1 = q.col + rr < w ? q.col + rr : w;
          for (int k = r0; k < r1; k++)
            for (int m = c0; m < c1; m++) map_bits[k][m] = 1'b1;
        end
      end
      ACT_CELL: begin
        if (q.row >= h || q.col >= w) rs.error = 1'b1;
        else rs.occupied = map_bits[q.row][q.col];
      end
      default: begin
        side = q.coarse ? cfg_cell * 2 : cfg_cell;
        if (side == 0 || q.row >= h / side || q.col >= w / side) rs.error = 1'b1;
        else
          for (int k = q.row * side; k < q.row * side + side; k++)
            for (int m = q.col * side; m < q.col * side + side; m++)
              if (k < 256 && m < 256 && map_bits[k][m]) rs.occupied = 1'b1;
      end
    endcase
    return rs;
  endfunction

  // request driver with random idle bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsps.insert(expected_rsps.size(), predict_map(in_data));
        void'(pending_reqs.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 15);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_reqs[0];
        end
      end else in_valid <= 1'b0;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result monitor and receiver stalls
  int recv_gap = 0;
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (out_data.occupied !== exp_r.occupied) begin
            $error("occupied expected %0b actual %0b", exp_r.occupied, out_data.occupied);
            fail_count++;
          end
          if (out_data.error !== exp_r.error) begin
            $error("error expected %0b actual %0b", exp_r.error, out_data.error);
            fail_count++;
          end
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MAP_WIDTH:  cfg_width = val & 9'h1FF;
      REG_MAP_HEIGHT: cfg_height = val & 9'h1FF;
      REG_RADIUS:     cfg_radius = val & 5'h1F;
      default:        cfg_cell = val & 6'h3F;
    endcase
  endtask

  task automatic drain_map;
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic req_t rand_req(int unsigned w, int unsigned h);
    req_t q;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    q.action = $urandom_range(0, 99) < 2 ? ACT_CLEAR : 2'($urandom_range(1, 3));
    if ($urandom_range(0, 9) != 0) begin
      q.row = 8'($urandom_range(0, h > 0 ? h - 1 : 0));
      q.col = 8'($urandom_range(0, w > 0 ? w - 1 : 0));
    end
    if (q.action == ACT_BLOCK && $urandom_range(0, 3) != 0) begin
      q.row = 8'($urandom_range(0, 12));
      q.col = 8'($urandom_range(0, 12));
    end
    if (q.action == ACT_PUT && $urandom_range(0, 2) != 0) {q.red, q.green, q.blue} = '0;
    return q;
  endfunction

  function automatic req_t mk(logic [1:0] a, int r, int c, int rgb, bit cs);
    req_t q;
    q.action = a; q.row = 8'(r); q.col = 8'(c);
    q.red = 8'(rgb); q.green = 8'(rgb); q.blue = 8'(rgb); q.coarse = cs;
    return q;
  endfunction

  typedef struct { int unsigned w, h, r, s; } phase_cfg_t;

  initial begin
    phase_cfg_t phases[6];
    phases[0] = '{256, 256, 3, 10};
    phases[1] = '{1, 1, 0, 1};
    phases[2] = '{40, 30, 31, 32};
    phases[3] = '{300, 511, 5, 4};
    phases[4] = '{0, 100, 2, 0};
    phases[5] = '{64, 48, 1, 3};
    cfg_width = 256; cfg_height = 256; cfg_radius = 3; cfg_cell = 10;
    for (int k = 0; k < 256; k++) map_bits[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every action, out of range, free over marked
    queue_req(mk(ACT_PUT, 0, 0, 0, 0));
    queue_req(mk(ACT_PUT, 255, 255, 0, 0));
    queue_req(mk(ACT_PUT, 100, 100, 8'hFF, 0));
    queue_req(mk(ACT_PUT, 2, 2, 1, 0));
    queue_req(mk(ACT_CELL, 0, 0, 0, 0));
    queue_req(mk(ACT_CELL, 2, 2, 0, 0));
    queue_req(mk(ACT_CELL, 3, 3, 0, 0));
    queue_req(mk(ACT_CELL, 254, 254, 0, 0));
    queue_req(mk(ACT_CELL, 255, 255, 0, 0));
    queue_req(mk(ACT_BLOCK, 0, 0, 0, 0));
    queue_req(mk(ACT_BLOCK, 24, 24, 0, 0));
    queue_req(mk(ACT_BLOCK, 25, 0, 0, 0));
    queue_req(mk(ACT_BLOCK, 12, 12, 0, 1));
    queue_req(mk(ACT_BLOCK, 0, 13, 0, 1));
    queue_req(mk(ACT_CLEAR, 0, 0, 0, 0));
    queue_req(mk(ACT_CELL, 0, 0, 0, 0));
    drain_map();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MAP_WIDTH, phases[p].w);
      write_reg(REG_MAP_HEIGHT, phases[p].h);
      write_reg(REG_RADIUS, phases[p].r);
      write_reg(REG_CELL_SIZE, phases[p].s);
      if (p == 5) quiet_tail = 1'b1;
      for (int n = 0; n < 90; n++) queue_req(rand_req(phases[p].w, phases[p].h));
      if (p == 2) begin
        // long receiver hold-off while requests keep coming
        hold_start = 1'b1;
      end
      drain_map();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ogid_pkg.sv
rtl/ogid_ctrl.sv
rtl/ogid_dp.sv
rtl/occupancy_grid_inflate_downsample.sv
dv/tb_occupancy_grid_inflate_downsample.sv
